/* rtl/tmprof_pkg.sv */
// Shared types and constants for the trapezoidal motion profile block.
package tmprof_pkg;

  // Input op codes
  localparam logic OpSet  = 1'b0;
  localparam logic OpTick = 1'b1;

  // Configuration register indexes
  localparam logic CfgMaxVelocity     = 1'b0;
  localparam logic CfgMaxAcceleration = 1'b1;

  localparam int unsigned CfgW      = 31;
  localparam logic [CfgW-1:0] CfgReset = 31'd65536;

  // Turn-distance divider: quotient bits kept before saturation takes over
  localparam int unsigned DivSteps = 34;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_EVAL,
    ST_DIV,
    ST_COMMIT
  } tmprof_state_e;

  typedef struct packed {
    logic load;        // capture the input beat
    logic mul_first;   // vmax^2 or amax*dt into product A
    logic mul_second;  // dist*amax or vel*dt into product B
    logic eval;        // pick midpoint or long-move turn
    logic div_init;
    logic div_step;
    logic commit;      // update profile state
  } tmprof_cmd_t;

  typedef struct packed {
    logic op_tick;
    logic long_move;
  } tmprof_stat_t;

endpackage

/* rtl/tmprof_ctrl.sv */
// Sequencer for the motion profile: multiplier steps, divider loop, commit.
module tmprof_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  tmprof_pkg::tmprof_stat_t stat_i,
  output tmprof_pkg::tmprof_cmd_t  cmd_o
);
  import tmprof_pkg::*;

  tmprof_state_e       state_q, state_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MUL1;
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_EVAL;
      ST_EVAL: begin
        if (!stat_i.op_tick && stat_i.long_move) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE:  cmd_o.load       = accept;
      ST_MUL1:  cmd_o.mul_first  = 1'b1;
      ST_MUL2:  cmd_o.mul_second = 1'b1;
      ST_EVAL: begin
        cmd_o.eval     = 1'b1;
        cmd_o.div_init = !stat_i.op_tick && stat_i.long_move;
      end
      ST_DIV:   cmd_o.div_step   = 1'b1;
      ST_COMMIT: begin
        cmd_o.commit = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/tmprof_dp.sv */
// Datapath: config and profile registers, shared multiplier, serial divider.
module tmprof_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [tmprof_pkg::CfgW-1:0] cfg_data_i,
  input  logic                       in_op_i,
  input  logic signed [31:0]         in_current_position_i,
  input  logic signed [31:0]         in_target_setpoint_i,
  input  logic [15:0]                in_elapsed_time_i,
  input  tmprof_pkg::tmprof_cmd_t    cmd_i,
  output tmprof_pkg::tmprof_stat_t   stat_o,
  output logic signed [31:0]         out_profile_position_o,
  output logic signed [31:0]         out_profile_velocity_o,
  output logic signed [31:0]         out_profile_acceleration_o,
  output logic                       out_at_setpoint_o
);
  import tmprof_pkg::*;

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (v > hi) return 32'sh7FFFFFFF;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

  // configuration
  logic [CfgW-1:0] vmax_q, amax_q;

  // profile state
  logic signed [31:0] pos_q, vel_q, acc_q, goal_q, turn_q;
  logic               ticked_q;

  // captured beat
  logic               op_q;
  logic signed [31:0] start_q, target_q;
  logic [15:0]        dt_q;

  // products, divider
  logic [63:0]          prod_a_q, prod_b_q;
  logic [31:0]          rem_q;
  logic [DivSteps-1:0]  dlow_q, quo_q;
  logic                 ovf_q;
  logic                 use_mid_q;

  logic signed [32:0] diff33, dist33, sum33;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [31:0]        trial;
  logic               trial_ge;
  logic               long_move;

  logic signed [31:0] mid, turn_long, acc_set;
  logic signed [35:0] g36, h36;

  logic [30:0]        dv;
  logic signed [31:0] step;
  logic signed [32:0] np33;
  logic signed [33:0] v34, dv34, vmax34, nv34;
  logic signed [31:0] nv, acc_tick, np;

  // set-command geometry
  assign diff33 = {target_q[31], target_q} - {start_q[31], start_q};
  assign dist33 = diff33[32] ? -diff33 : diff33;
  assign sum33  = {target_q[31], target_q} + {start_q[31], start_q};
  assign mid    = sum33[32:1];

  // one shared signed multiplier
  always_comb begin
    if (op_q == OpTick) begin
      mul_a = {2'b00, amax_q};
      mul_b = {17'd0, dt_q};
      if (cmd_i.mul_second) begin
        mul_a = {vel_q[31], vel_q};
      end
    end else begin
      mul_a = {2'b00, vmax_q};
      mul_b = {2'b00, vmax_q};
      if (cmd_i.mul_second) begin
        mul_a = dist33;
        mul_b = {2'b00, amax_q};
      end
    end
  end
  assign mul_p = mul_a * mul_b;

  // short move when amax is zero or dist*amax < vmax^2
  assign long_move = (amax_q != '0) && !(prod_b_q < prod_a_q);

  // restoring divide of (vmax^2 >> 1) by amax, one quotient bit per step
  assign trial    = {rem_q[30:0], dlow_q[DivSteps-1]};
  assign trial_ge = trial >= {1'b0, amax_q};

  assign g36       = {{4{target_q[31]}}, target_q};
  assign h36       = ovf_q ? (36'sd1 <<< DivSteps) : {{(36-DivSteps){1'b0}}, quo_q};
  assign turn_long = sat36((target_q > start_q) ? g36 - h36 : g36 + h36);
  assign acc_set   = (target_q < start_q) ? -$signed({1'b0, amax_q}) : $signed({1'b0, amax_q});

  // tick update
  assign dv     = prod_a_q[46:16];
  assign step   = prod_b_q[47:16];
  assign np33   = {pos_q[31], pos_q} + {step[31], step};
  assign np     = sat36({{3{np33[32]}}, np33});
  assign v34    = {{2{vel_q[31]}}, vel_q};
  assign dv34   = {3'b000, dv};
  assign vmax34 = {3'b000, vmax_q};

  always_comb begin
    if (turn_q < goal_q) begin
      if (pos_q > turn_q) begin
        nv34 = v34 - dv34;
        if (nv34 < 34'sd0) nv34 = 34'sd0;
      end else begin
        nv34 = v34 + dv34;
        if (nv34 > vmax34) nv34 = vmax34;
      end
    end else begin
      if (pos_q > turn_q) begin
        nv34 = v34 - dv34;
        if (nv34 < -vmax34) nv34 = -vmax34;
      end else begin
        nv34 = v34 + dv34;
        if (nv34 > 34'sd0) nv34 = 34'sd0;
      end
    end
  end

  assign nv = sat36({{2{nv34[33]}}, nv34});

  always_comb begin
    if (nv == vel_q)     acc_tick = '0;
    else if (nv > vel_q) acc_tick = $signed({1'b0, amax_q});
    else                 acc_tick = -$signed({1'b0, amax_q});
  end

  // control-visible registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmax_q   <= CfgReset;
      amax_q   <= CfgReset;
      pos_q    <= '0;
      vel_q    <= '0;
      acc_q    <= '0;
      goal_q   <= '0;
      turn_q   <= '0;
      ticked_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgMaxVelocity)     vmax_q <= cfg_data_i;
        if (cfg_index_i == CfgMaxAcceleration) amax_q <= cfg_data_i;
      end
      if (cmd_i.commit) begin
        if (op_q == OpTick) begin
          pos_q    <= np;
          vel_q    <= nv;
          acc_q    <= acc_tick;
          ticked_q <= 1'b1;
        end else begin
          pos_q  <= start_q;
          vel_q  <= '0;
          acc_q  <= acc_set;
          goal_q <= target_q;
          turn_q <= use_mid_q ? mid : turn_long;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_op_i;
      start_q  <= in_current_position_i;
      target_q <= in_target_setpoint_i;
      dt_q     <= in_elapsed_time_i;
    end
    if (cmd_i.mul_first)  prod_a_q <= mul_p[63:0];
    if (cmd_i.mul_second) prod_b_q <= mul_p[63:0];
    if (cmd_i.eval)       use_mid_q <= !long_move;
    if (cmd_i.div_init) begin
      rem_q  <= {5'd0, prod_a_q[61:35]};
      ovf_q  <= {4'd0, prod_a_q[61:35]} >= amax_q;
      dlow_q <= prod_a_q[34:1];
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? trial - {1'b0, amax_q} : trial;
      quo_q  <= {quo_q[DivSteps-2:0], trial_ge};
      dlow_q <= {dlow_q[DivSteps-2:0], 1'b0};
    end
  end

  assign stat_o.op_tick   = (op_q == OpTick);
  assign stat_o.long_move = long_move;

  assign out_profile_position_o     = pos_q;
  assign out_profile_velocity_o     = vel_q;
  assign out_profile_acceleration_o = acc_q;
  assign out_at_setpoint_o          = ticked_q && (vel_q == '0);

endmodule

/* rtl/trapezoidal_motion_profile_top.sv */
// Top level of the trapezoidal motion profile generator.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  cfg     | in        | cfg_we_i             | cfg_index_i, cfg_data_i (31 bit)
//  in      | in        | in_valid_i/in_stall_o| op, current_position, target_setpoint,
//          |           |                      | elapsed_time
//  out     | out       | out_valid_o/out_stall_i | profile_position, _velocity,
//          |           |                      | _acceleration, at_setpoint
//
// One beat at a time. A tick runs from accept through MUL1, MUL2 and EVAL to COMMIT;
// a set command does too on a short move, and on a long one adds the 34-step serial
// divider that forms vmax^2 / (2*amax). Both paths share one 33x33 multiplier.
// Reset clears the profile state and loads 1.0 into both limit registers.
// The result stays on the output ports until taken; the next input beat is
// accepted meanwhile, and its commit waits while out_stall_i holds the old one.
module trapezoidal_motion_profile_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [tmprof_pkg::CfgW-1:0] cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        in_op_i,
  input  logic signed [31:0]          in_current_position_i,
  input  logic signed [31:0]          in_target_setpoint_i,
  input  logic [15:0]                 in_elapsed_time_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          out_profile_position_o,
  output logic signed [31:0]          out_profile_velocity_o,
  output logic signed [31:0]          out_profile_acceleration_o,
  output logic                        out_at_setpoint_o
);
  import tmprof_pkg::*;

  tmprof_cmd_t  cmd;
  tmprof_stat_t stat;

  // controller: sequencing and both handshakes
  tmprof_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: the profile registers double as the output register
  tmprof_dp u_dp (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .cfg_we_i                   (cfg_we_i),
    .cfg_index_i                (cfg_index_i),
    .cfg_data_i                 (cfg_data_i),
    .in_op_i                    (in_op_i),
    .in_current_position_i      (in_current_position_i),
    .in_target_setpoint_i       (in_target_setpoint_i),
    .in_elapsed_time_i          (in_elapsed_time_i),
    .cmd_i                      (cmd),
    .stat_o                     (stat),
    .out_profile_position_o     (out_profile_position_o),
    .out_profile_velocity_o     (out_profile_velocity_o),
    .out_profile_acceleration_o (out_profile_acceleration_o),
    .out_at_setpoint_o          (out_at_setpoint_o)
  );

  // an accepted beat keeps the block busy the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted beat did not start processing");

  // a new result appears only at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised without an item in work");

  // at setpoint means the profile is at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_at_setpoint_o |-> (out_profile_velocity_o == 32'sd0))
    else $error("at_setpoint with nonzero velocity");

endmodule

/* tb/tb_trapezoidal_motion_profile_top.sv */
// Self-checking testbench for the trapezoidal motion profile generator.
module tb_trapezoidal_motion_profile_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tmprof_pkg::*;

  // Whole-run guard, far above the slowest legal run of about 500 beats.
  localparam int CycleLimit    = 600000;
  localparam int RandPhases    = 7;
  localparam int BeatsPerPhase = 62;
  localparam longint IntMax    = 64'sd2147483647;
  localparam longint IntMin    = -64'sd2147483648;

  // One result beat: profile state after the item.
  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic               at_setpoint;
  } motion_t;

  typedef enum logic {STEP_BEAT, STEP_LIMITS} step_kind_e;

  // Directed step: an input beat, or a new pair of limits (a = vmax, b = amax).
  typedef struct packed {
    step_kind_e  kind;
    logic        op;
    logic [31:0] a;      // start position / max_velocity
    logic [31:0] b;      // goal / max_acceleration
    logic [15:0] dt;
    logic        fixed;  // want below is typed in rather than predicted
    motion_t     want;
  } step_t;

  localparam int DirN = 28;
  localparam step_t DirectedSteps [DirN] = '{
    // tick before any set: profile stays at rest, but a tick has now happened
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'hFFFF, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b1}},
    // long move up at 1.0/1.0; accel +amax, at rest until the first tick
    '{STEP_BEAT, OpSet, 32'h0, 32'h0004_0000, 16'h0, 1'b1,
      '{32'h0, 32'h0, 32'h0001_0000, 1'b1}},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'h8000, 1'b0, '0},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'h8000, 1'b0, '0},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'hFFFF, 1'b0, '0},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'h0000, 1'b0, '0},
    // start equals goal at the top of the range: accel is +amax
    '{STEP_BEAT, OpSet, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 1'b1}},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'hFFFF, 1'b0, '0},
    // full-range moves both ways
    '{STEP_BEAT, OpSet, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 1'b1,
      '{32'h8000_0000, 32'h0, 32'h0001_0000, 1'b1}},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'hFFFF, 1'b0, '0},
    '{STEP_BEAT, OpSet, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000, 1'b1}},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'hFFFF, 1'b0, '0},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'hFFFF, 1'b0, '0},
    // huge vmax, tiny amax: every move is short, turn at the midpoint
    '{STEP_LIMITS, OpSet, 32'h7FFF_FFFF, 32'h1, 16'h0, 1'b0, '0},
    '{STEP_BEAT, OpSet, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 1'b1,
      '{32'h8000_0000, 32'h0, 32'h1, 1'b1}},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'hFFFF, 1'b0, '0},
    '{STEP_BEAT, OpSet, 32'h0, 32'h0000_1000, 16'h0, 1'b0, '0},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'h1234, 1'b0, '0},
    // tiny vmax, huge amax: turn distance rounds to zero
    '{STEP_LIMITS, OpSet, 32'h1, 32'h7FFF_FFFF, 16'h0, 1'b0, '0},
    '{STEP_BEAT, OpSet, 32'h0, 32'hFFFF_0000, 16'h0, 1'b1,
      '{32'h0, 32'h0, 32'h8000_0001, 1'b1}},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'hFFFF, 1'b0, '0},
    // both limits zero: no division, accel zero
    '{STEP_LIMITS, OpSet, 32'h0, 32'h0, 16'h0, 1'b0, '0},
    '{STEP_BEAT, OpSet, 32'h0001_0000, 32'h0003_0000, 16'h0, 1'b1,
      '{32'h0001_0000, 32'h0, 32'h0, 1'b1}},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'hFFFF, 1'b0, '0},
    // zero vmax only: turn at the goal
    '{STEP_LIMITS, OpSet, 32'h0, 32'h0001_0000, 16'h0, 1'b0, '0},
    '{STEP_BEAT, OpSet, 32'h0003_0000, 32'h0001_0000, 16'h0, 1'b1,
      '{32'h0003_0000, 32'h0, 32'hFFFF_0000, 1'b1}},
    '{STEP_BEAT, OpTick, 32'h0, 32'h0, 16'h8000, 1'b0, '0},
    '{STEP_LIMITS, OpSet, 32'h0001_0000, 32'h0001_0000, 16'h0, 1'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               in_op_i;
  logic signed [31:0] in_current_position_i;
  logic signed [31:0] in_target_setpoint_i;
  logic [15:0]        in_elapsed_time_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] out_profile_position_o;
  logic signed [31:0] out_profile_velocity_o;
  logic signed [31:0] out_profile_acceleration_o;
  logic               out_at_setpoint_o;

  trapezoidal_motion_profile_top u_dut (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .cfg_we_i                   (cfg_we_i),
    .cfg_index_i                (cfg_index_i),
    .cfg_data_i                 (cfg_data_i),
    .in_valid_i                 (in_valid_i),
    .in_stall_o                 (in_stall_o),
    .in_op_i                    (in_op_i),
    .in_current_position_i      (in_current_position_i),
    .in_target_setpoint_i       (in_target_setpoint_i),
    .in_elapsed_time_i          (in_elapsed_time_i),
    .out_valid_o                (out_valid_o),
    .out_stall_i                (out_stall_i),
    .out_profile_position_o     (out_profile_position_o),
    .out_profile_velocity_o     (out_profile_velocity_o),
    .out_profile_acceleration_o (out_profile_acceleration_o),
    .out_at_setpoint_o          (out_at_setpoint_o)
  );

  // Shadow of the block's profile state and limits.
  logic signed [31:0] prof_pos    = '0;
  logic signed [31:0] prof_vel    = '0;
  logic signed [31:0] prof_acc    = '0;
  logic signed [31:0] prof_goal   = '0;
  logic signed [31:0] prof_turn   = '0;
  logic               prof_ticked = 1'b0;
  logic [CfgW-1:0]    lim_vel     = CfgReset;
  logic [CfgW-1:0]    lim_acc     = CfgReset;

  motion_t motion_queue [$];   // expected result beats, oldest first
  int      outstanding = 0;
  int      errors      = 0;
  int      beats_sent  = 0;
  int      cycles      = 0;
  bit      calm        = 1'b0; // no idling on either side while set
  logic    beat_fixed;         // travels alongside the input beat
  motion_t beat_want;
  motion_t predicted;

  always #1ns clk_i = ~clk_i;

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > IntMax) return 32'sh7FFF_FFFF;
    if (x < IntMin) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Steps the shadow state by one input item and returns the result beat.
  function automatic motion_t advance_profile(input logic op,
                                              input logic signed [31:0] start_pos,
                                              input logic signed [31:0] goal_pos,
                                              input logic [15:0] dt);
    longint          s, g, vmax, amax, v, dv, nv, np, dtl, acc_sel, mid;
    longint unsigned span, vsq, half;
    motion_t         r;
    vmax = 0;
    vmax[CfgW-1:0] = lim_vel;
    amax = 0;
    amax[CfgW-1:0] = lim_acc;
    dtl = 0;
    dtl[15:0] = dt;
    if (op == OpSet) begin
      s = start_pos;
      g = goal_pos;
      span = (g >= s) ? g - s : s - g;
      vsq = vmax * vmax;
      acc_sel = (g < s) ? -amax : amax;
      prof_goal = goal_pos;
      prof_pos = start_pos;
      prof_vel = '0;
      prof_acc = acc_sel[31:0];
      if (amax == 0 || span * amax < vsq) begin
        // short move: turn at floor of the midpoint
        mid = (g + s) >>> 1;
        prof_turn = mid[31:0];
      end else begin
        half = vsq / (2 * amax);
        prof_turn = (g > s) ? clamp32(g - longint'(half)) : clamp32(g + longint'(half));
      end
    end else begin
      v = prof_vel;
      dv = (amax * dtl) >>> 16;
      np = longint'(prof_pos) + ((v * dtl) >>> 16);
      if (prof_turn < prof_goal) begin
        if (prof_pos > prof_turn) begin
          nv = v - dv;
          if (nv < 0) nv = 0;
        end else begin
          nv = v + dv;
          if (nv > vmax) nv = vmax;
        end
      end else begin
        if (prof_pos > prof_turn) begin
          nv = v - dv;
          if (nv < -vmax) nv = -vmax;
        end else begin
          nv = v + dv;
          if (nv > 0) nv = 0;
        end
      end
      nv = clamp32(nv);
      acc_sel = (nv > v) ? amax : -amax;
      prof_acc = (nv == v) ? '0 : acc_sel[31:0];
      prof_pos = clamp32(np);
      prof_vel = nv[31:0];
      prof_ticked = 1'b1;
    end
    r.position = prof_pos;
    r.velocity = prof_vel;
    r.acceleration = prof_acc;
    r.at_setpoint = (prof_vel == 0) && prof_ticked;
    return r;
  endfunction

  // Mostly short gaps, some medium, a few long; none while calm.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 16'($urandom_range(16'h1000, 16'h6000));
    if (r < 95) return 16'($urandom);
    return r[0] ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Called at a rising edge; returns at the edge where the beat was taken.
  task automatic send_beat(input logic op, input logic [31:0] cur, goal,
                           input logic [15:0] dt, input logic fixed, input motion_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    in_op_i               <= op;
    in_current_position_i <= cur;
    in_target_setpoint_i  <= goal;
    in_elapsed_time_i     <= dt;
    beat_fixed            <= fixed;
    beat_want             <= want;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // Hold off input until every expected beat is back, then let the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Only called when idle; one write per register.
  task automatic set_limits(input logic [CfgW-1:0] vmax, amax);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgMaxVelocity;
    cfg_data_i  <= vmax;
    @(posedge clk_i);
    cfg_index_i <= CfgMaxAcceleration;
    cfg_data_i  <= amax;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Scoreboard: predict on every accepted input beat, check every taken result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgMaxVelocity) lim_vel = cfg_data_i;
        else lim_acc = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        predicted = advance_profile(in_op_i, in_current_position_i,
                                    in_target_setpoint_i, in_elapsed_time_i);
        motion_queue.push_back(beat_fixed ? beat_want : predicted);
        outstanding++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (motion_queue.size() == 0) begin
          $display("%0t ns: result beat with nothing pending", $time);
          errors++;
        end else begin
          check_field("position", motion_queue[0].position, out_profile_position_o);
          check_field("velocity", motion_queue[0].velocity, out_profile_velocity_o);
          check_field("acceleration", motion_queue[0].acceleration,
                      out_profile_acceleration_o);
          check_field("at_setpoint", {31'd0, motion_queue[0].at_setpoint},
                      {31'd0, out_at_setpoint_o});
          void'(motion_queue.pop_front());
          outstanding--;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: random stall bursts, free-running while calm.
  initial begin
    int stall_len;
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Stimulus: directed steps, then random phases under varied limits.
  initial begin
    logic [CfgW-1:0] vmax, amax;
    longint          st, span, gl;
    int              n_ticks, n_noise;
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = CfgMaxVelocity;
    cfg_data_i            = '0;
    in_valid_i            = 1'b0;
    in_op_i               = OpSet;
    in_current_position_i = '0;
    in_target_setpoint_i  = '0;
    in_elapsed_time_i     = '0;
    beat_fixed            = 1'b0;
    beat_want             = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirN; i++) begin
      if (DirectedSteps[i].kind == STEP_LIMITS) begin
        wait_idle();
        set_limits(DirectedSteps[i].a[CfgW-1:0], DirectedSteps[i].b[CfgW-1:0]);
      end else begin
        send_beat(DirectedSteps[i].op, DirectedSteps[i].a, DirectedSteps[i].b,
                  DirectedSteps[i].dt, DirectedSteps[i].fixed, DirectedSteps[i].want);
      end
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      case ($urandom_range(0, 7))
        0: begin
          vmax = 31'h7FFF_FFFF;
          amax = 31'h7FFF_FFFF;
        end
        1: begin
          vmax = 31'($urandom);
          amax = 31'($urandom);
        end
        2: begin
          vmax = 31'($urandom_range(32'h4000, 32'h40000));
          amax = '0;
        end
        3: begin
          vmax = '0;
          amax = 31'($urandom_range(32'h4000, 32'h80000));
        end
        default: begin
          vmax = 31'($urandom_range(32'h4000, 32'h40000));
          amax = 31'($urandom_range(32'h4000, 32'h80000));
        end
      endcase
      // a change of limits always drains the block first
      wait_idle();
      set_limits(vmax, amax);

      while (beats_sent < DirN + (ph + 1) * BeatsPerPhase) begin
        calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 99) < 15) begin
          // noise: anything the fields allow, including back-to-back sets
          n_noise = $urandom_range(1, 4);
          repeat (n_noise)
            send_beat(logic'($urandom_range(0, 1)), $urandom, $urandom,
                      16'($urandom), 1'b0, '0);
        end else begin
          // well-formed move: a set scaled to vmax, then a run of ticks
          st = longint'($urandom_range(0, 32'h0080_0000)) - 64'sh40_0000;
          span = (longint'(vmax) * $urandom_range(0, 64)) >>> 4;
          span = span + $urandom_range(0, 255);
          gl = $urandom_range(0, 1) ? st + span : st - span;
          send_beat(OpSet, st[31:0], clamp32(gl), 16'($urandom), 1'b0, '0);
          n_ticks = $urandom_range(3, 40);
          repeat (n_ticks)
            send_beat(OpTick, $urandom, $urandom, pick_dt(), 1'b0, '0);
        end
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
    end

    calm = 1'b0;
    wait_idle();
    // catch any stray result beats after the last expected one
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
